### rtl/text_console_cursor_engine_top_defines.svh
// Assertion macros used by the cursor engine checker.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define TCCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcce check failed");

// Next-cycle implication, disabled while reset is low
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcce check failed");

`endif

### rtl/tcce_pkg.sv
// Shared types, constants and helpers of the text console cursor engine.
`default_nettype none
package tcce_pkg;

    // Screen geometry
    localparam int SCREEN_COLUMNS = 80;
    localparam int MAX_ROWS       = 32;

    // Field and state widths
    localparam int CH_W    = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int LIM_W   = 6;
    localparam int CNT_W   = 12;
    localparam int ADDR_W  = 12;
    localparam int VAL_W   = 16;
    localparam int OUT_W   = 48;

    // Decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [CH_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CH_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CH_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CH_W-1:0] CH_KILL_LINE = 8'h15;
    localparam logic [CH_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Reset values of the configuration registers
    localparam logic [VAL_W-1:0] COLOR_RESET = 16'h0700;
    localparam logic [LIM_W-1:0] ROWS_RESET  = 6'd25;

    // Configuration register indexes
    typedef enum logic {
        REG_COLOR_ATTRIBUTE = 1'b0,
        REG_ROWS_IN_USE     = 1'b1
    } t_reg_index;

    // Character classes found by the front end
    typedef enum logic [2:0] {
        K_PRINT,
        K_NEWLINE,
        K_TAB,
        K_BACKSPACE,
        K_IGNORE
    } t_kind;

    // One queued request
    typedef struct packed {
        t_kind           kind;
        logic [CH_W-1:0] ch;
    } t_entry;

    // Queue to back end handshake
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_queue_out;

    // One result
    typedef struct packed {
        logic              cell_write;
        logic [ADDR_W-1:0] cell_address;
        logic [VAL_W-1:0]  cell_value;
        logic              clear_after;
        logic              cursor_update;
        logic [ADDR_W-1:0] cursor_position;
    } t_result;

    // Linear cell index of a row and column
    function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col);
    endfunction

endpackage
`default_nettype wire

### rtl/tcce_front.sv
// Front end: accepts characters and classifies them for the back end.
`default_nettype none
module tcce_front import tcce_pkg::*; (
    input  wire logic            i_queue_full,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [CH_W-1:0] s_axis_tdata,   // [7:0] character
    output logic                 o_push,
    output t_entry               o_entry
);

    // Accept while the queue has room
    assign s_axis_tready = !i_queue_full;
    assign o_push        = s_axis_tvalid && !i_queue_full;

    // Classify the character byte
    always_comb begin
        o_entry.ch = s_axis_tdata;
        unique case (s_axis_tdata)
            CH_NEWLINE:   o_entry.kind = K_NEWLINE;
            CH_TAB:       o_entry.kind = K_TAB;
            CH_BACKSPACE: o_entry.kind = K_BACKSPACE;
            CH_KILL_LINE: o_entry.kind = K_IGNORE;
            default:      o_entry.kind = K_PRINT;
        endcase
    end

endmodule
`default_nettype wire

### rtl/tcce_queue.sv
// Short queue that decouples the front end from the back end.
`default_nettype none
module tcce_queue import tcce_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output t_queue_out  o_head
);

    t_entry             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

### rtl/tcce_back.sv
// Back end: cursor state, configuration registers and the result register.
`default_nettype none
module tcce_back import tcce_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [VAL_W-1:0] i_cfg_data,
    input  wire t_queue_out       i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_result               o_result
);

    logic [VAL_W-1:0] r_color;
    logic [LIM_W-1:0] r_rows;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_valid;
    t_result          r_result, n_result;

    logic [LIM_W-1:0] limit;
    logic [LIM_W-1:0] row_inc;
    logic [COL_W:0]   tab_col;
    logic [COL_W:0]   next_col;
    logic             adv;
    logic             wr;
    logic             mv;
    logic             use_new;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;

    // Load the result register when it is empty or being taken
    assign o_pop    = i_head.valid && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Effective row limit: clamp to the screen, zero acts as one
    always_comb begin
        if (r_rows > LIM_W'(MAX_ROWS)) begin
            limit = LIM_W'(MAX_ROWS);
        end else if (r_rows == '0) begin
            limit = LIM_W'(1);
        end else begin
            limit = r_rows;
        end
    end

    // Work out the next cursor and the result
    always_comb begin
        row_inc  = LIM_W'(r_row) + LIM_W'(1);
        tab_col  = {1'b0, r_col[COL_W-1:3], 3'b000} + (COL_W+1)'(8);
        next_col = (COL_W+1)'(r_col) + (COL_W+1)'(1);
        n_col    = r_col;
        n_row    = r_row;
        n_cnt    = r_cnt;
        adv      = 1'b0;
        wr       = 1'b0;
        mv       = 1'b0;
        use_new  = 1'b0;
        n_result = '0;

        unique case (i_head.entry.kind)
            K_NEWLINE: begin
                adv   = 1'b1;
                n_cnt = '0;
                mv    = 1'b1;
            end
            K_IGNORE: begin
                mv = 1'b0;
            end
            K_BACKSPACE: begin
                if (r_cnt != '0) begin
                    if (r_col == '0) begin
                        n_col = COL_W'(SCREEN_COLUMNS - 1);
                        if (r_row != '0) begin
                            n_row = r_row - 1'b1;
                        end
                    end else begin
                        n_col = r_col - 1'b1;
                    end
                    wr      = 1'b1;
                    use_new = 1'b1;
                    n_cnt   = r_cnt - 1'b1;
                    mv      = 1'b1;
                end
            end
            K_TAB: begin
                if (tab_col >= (COL_W+1)'(SCREEN_COLUMNS)) begin
                    adv = 1'b1;
                end else begin
                    n_col = tab_col[COL_W-1:0];
                end
                if (r_cnt != COUNT_MAX) begin
                    n_cnt = r_cnt + 1'b1;
                end
                mv = 1'b1;
            end
            K_PRINT: begin
                wr = 1'b1;
                if (next_col >= (COL_W+1)'(SCREEN_COLUMNS)) begin
                    adv = 1'b1;
                end else begin
                    n_col = next_col[COL_W-1:0];
                end
                if (r_cnt != COUNT_MAX) begin
                    n_cnt = r_cnt + 1'b1;
                end
                mv = 1'b1;
            end
            default: begin
                mv = 1'b0;
            end
        endcase

        // Move to the next line, wrapping to the top with a clear
        if (adv) begin
            n_col = '0;
            if (row_inc >= limit) begin
                n_row                = '0;
                n_result.clear_after = 1'b1;
            end else begin
                n_row = row_inc[ROW_W-1:0];
            end
        end

        cell_row = use_new ? n_row : r_row;
        cell_col = use_new ? n_col : r_col;
        if (wr) begin
            n_result.cell_write   = 1'b1;
            n_result.cell_address = cell_index(cell_row, cell_col);
            n_result.cell_value   = (use_new ? VAL_W'(CH_SPACE) : VAL_W'(i_head.entry.ch))
                                    | r_color;
        end

        // Drop the cursor write while the cursor sits outside the screen
        if (mv && (n_col < COL_W'(SCREEN_COLUMNS)) && (LIM_W'(n_row) < limit)) begin
            n_result.cursor_update   = 1'b1;
            n_result.cursor_position = cell_index(n_row, n_col);
        end
    end

    // Control state, cursor and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_cnt   <= '0;
            r_color <= COLOR_RESET;
            r_rows  <= ROWS_RESET;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_col   <= n_col;
                r_row   <= n_row;
                r_cnt   <= n_cnt;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_reg_index'(i_cfg_index))
                    REG_COLOR_ATTRIBUTE: r_color <= i_cfg_data;
                    REG_ROWS_IN_USE:     r_rows  <= i_cfg_data[LIM_W-1:0];
                    default:             r_rows  <= r_rows;
                endcase
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule
`default_nettype wire

### rtl/text_console_cursor_engine_top.sv
// Top level of the text console cursor engine.
//
//  channel   direction  bits  contents
//  s_axis    in         8     character
//  m_axis    out        48    cell and cursor result, one per character
//  i_cfg     in         16    register write: 0 color attribute, 1 rows in use
//
// One character per cycle sustained while m_axis_tready stays high; a taken request is
// written into the queue and then popped into the result register, where it is valid.
// The two-entry queue keeps taking requests while the result register is stalled.
// Synchronous active-low reset clears the cursor, count, queue and result valid,
// and loads color 0x0700 and 25 rows.
`default_nettype none
module text_console_cursor_engine_top import tcce_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [CH_W-1:0]  s_axis_tdata,   // [7:0] character
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // [0] cell_write, [12:1] cell_address, [28:13] cell_value, [29] clear_after,
    // [30] cursor_update, [42:31] cursor_position, [47:43] zero
    output logic [OUT_W-1:0]      m_axis_tdata,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [VAL_W-1:0] i_cfg_data
);

    logic       push;
    logic       pop;
    logic       queue_full;
    t_entry     entry;
    t_queue_out head;
    t_result    result;

    tcce_front u_front (
        .i_queue_full  (queue_full),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_push        (push),
        .o_entry       (entry)
    );

    tcce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_head  (head)
    );

    tcce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    // Pack the result, first field lowest
    assign m_axis_tdata = {5'b00000,
                           result.cursor_position,
                           result.cursor_update,
                           result.clear_after,
                           result.cell_value,
                           result.cell_address,
                           result.cell_write};

endmodule
`default_nettype wire

### rtl/tcce_checker.sv
// Port-level checks of the cursor engine, bound to the top level.
`default_nettype none
`include "text_console_cursor_engine_top_defines.svh"
module tcce_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);

    // A stalled result holds
    `TCCE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // No cell write means zero address and value
    `TCCE_ASSERT_NOW(a_cell_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[28:1] == 28'd0)

    // No cursor write means zero position
    `TCCE_ASSERT_NOW(a_pos_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[30], m_axis_tdata[42:31] == 12'd0)

    // Written cells stay on the screen
    `TCCE_ASSERT_NOW(a_addr_range, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[12:1] < 12'd2560)

endmodule

bind text_console_cursor_engine_top tcce_checker u_tcce_checker (.*);
`default_nettype wire

### tb/text_console_cursor_engine_top_tb.sv
// Self-checking testbench of the text console cursor engine top level.
`timescale 1ns / 1ps
module text_console_cursor_engine_top_tb;
    import tcce_pkg::*;

    // Phases of the random part and requests per phase
    localparam int PHASE_COUNT     = 9;
    localparam int PHASE_REQUESTS  = 160;
    localparam int STALL_CYCLES    = 120;
    localparam int REPORT_LIMIT    = 10;
    localparam int SETTLE_CYCLES   = 8;

    // Directed opening: printable extremes, backspace down to and past zero count,
    // the ignored code, newline, a run of tabs past the edge, backspace at column 0
    localparam logic [CH_W-1:0] OPENING_CHARS [24] = '{
        8'h41, 8'h00, 8'hFF, 8'h7F, CH_SPACE,
        CH_BACKSPACE, CH_BACKSPACE, CH_BACKSPACE, CH_BACKSPACE, CH_BACKSPACE,
        CH_BACKSPACE, CH_KILL_LINE, CH_NEWLINE,
        CH_TAB, CH_TAB, CH_TAB, CH_TAB, CH_TAB,
        CH_TAB, CH_TAB, CH_TAB, CH_TAB, CH_TAB,
        CH_BACKSPACE
    };

    // Cursor predictor and store of expected cell and cursor results
    class console_scoreboard;
        t_result     expected_q[$];
        int unsigned color;
        int unsigned rows_in_use;
        int unsigned col;
        int unsigned row;
        int unsigned line_count;
        int          mismatches;

        function new();
            color       = 32'(COLOR_RESET);
            rows_in_use = 32'(ROWS_RESET);
            col         = 0;
            row         = 0;
            line_count  = 0;
            mismatches  = 0;
        endfunction

        function void write_reg(t_reg_index idx, logic [VAL_W-1:0] data);
            if (idx == REG_COLOR_ATTRIBUTE) begin
                color = 32'(data);
            end else begin
                rows_in_use = 32'(data[LIM_W-1:0]);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Go to column 0 of the next row; report a screen clear on wrap to the top
        function bit line_feed(int unsigned lim);
            col = 0;
            row++;
            if (row >= lim) begin
                row = 0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void bump_count();
            if (line_count < COUNT_MAX) line_count++;
        endfunction

        // Work out the result of one accepted character
        function void note_request(logic [CH_W-1:0] ch);
            t_result     r;
            int unsigned lim;
            int unsigned tab_col;
            bit          moved;
            r     = '0;
            moved = 1'b0;
            lim   = (rows_in_use > MAX_ROWS) ? MAX_ROWS : rows_in_use;
            if (lim == 0) lim = 1;
            case (ch)
                CH_NEWLINE: begin
                    r.clear_after = line_feed(lim);
                    line_count    = 0;
                    moved         = 1'b1;
                end
                CH_KILL_LINE: ;
                CH_BACKSPACE: begin
                    if (line_count != 0) begin
                        if (col == 0) begin
                            col = SCREEN_COLUMNS - 1;
                            if (row > 0) row--;
                        end else begin
                            col--;
                        end
                        r.cell_write   = 1'b1;
                        r.cell_address = ADDR_W'(row * SCREEN_COLUMNS + col);
                        r.cell_value   = VAL_W'(CH_SPACE) | VAL_W'(color);
                        line_count--;
                        moved = 1'b1;
                    end
                end
                CH_TAB: begin
                    tab_col = (col & 32'hFFFF_FFF8) + 8;
                    if (tab_col >= SCREEN_COLUMNS) begin
                        r.clear_after = line_feed(lim);
                    end else begin
                        col = tab_col;
                    end
                    bump_count();
                    moved = 1'b1;
                end
                default: begin
                    r.cell_write   = 1'b1;
                    r.cell_address = ADDR_W'(row * SCREEN_COLUMNS + col);
                    r.cell_value   = VAL_W'(ch) | VAL_W'(color);
                    col++;
                    if (col >= SCREEN_COLUMNS) r.clear_after = line_feed(lim);
                    bump_count();
                    moved = 1'b1;
                end
            endcase
            col &= 32'h7F;
            row &= 32'h1F;
            // Hold the hardware cursor while the row sits outside the limit
            if (moved && col < SCREEN_COLUMNS && row < lim) begin
                r.cursor_update   = 1'b1;
                r.cursor_position = ADDR_W'(row * SCREEN_COLUMNS + col);
            end
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t mismatch in %s: expected 0x%0h, got 0x%0h",
                             $realtime, name, want, got);
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [OUT_W-1:0] d);
            t_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t result 0x%0h with nothing expected", $realtime, d);
                return;
            end
            want = expected_q.pop_front();
            check_field("cell_write",      32'(want.cell_write),      32'(d[0]));
            check_field("cell_address",    32'(want.cell_address),    32'(d[12:1]));
            check_field("cell_value",      32'(want.cell_value),      32'(d[28:13]));
            check_field("clear_after",     32'(want.clear_after),     32'(d[29]));
            check_field("cursor_update",   32'(want.cursor_update),   32'(d[30]));
            check_field("cursor_position", 32'(want.cursor_position), 32'(d[42:31]));
            check_field("padding",         0,                         32'(d[47:43]));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [CH_W-1:0]   s_axis_tdata;    // [7:0] character
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // [0] cell_write, [12:1] cell_address, [28:13] cell_value, [29] clear_after,
    // [30] cursor_update, [42:31] cursor_position, [47:43] zero
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              i_cfg_we;
    t_reg_index        i_cfg_index;
    logic [VAL_W-1:0]  i_cfg_data;

    console_scoreboard sb;
    int                src_idle_pct;
    int                sink_idle_pct;
    bit                stall_req;
    int                stall_left;

    text_console_cursor_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Drive the result ready: random idling, or a counted hold-off on request
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (stall_req) begin
            stall_req     = 1'b0;
            m_axis_tready <= 1'b0;
            stall_left    <= STALL_CYCLES;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // Offer one character, idling first at random, and note it once taken
    task automatic send_char(input logic [CH_W-1:0] ch);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(ch);
        @(negedge i_clk);
    endtask

    // Drop the request and wait until every expected result is out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Write both registers on consecutive cycles
    task automatic configure(input logic [VAL_W-1:0] color, input logic [VAL_W-1:0] rows);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_COLOR_ATTRIBUTE;
        i_cfg_data  <= color;
        @(negedge i_clk);
        i_cfg_index <= REG_ROWS_IN_USE;
        i_cfg_data  <= rows;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(REG_COLOR_ATTRIBUTE, color);
        sb.write_reg(REG_ROWS_IN_USE, rows);
    endtask

    // Mostly text with line control, plus ignored codes and arbitrary bytes
    function automatic logic [CH_W-1:0] pick_char(int newline_pct);
        int n;
        n = $urandom_range(0, 99);
        if (n < newline_pct)      return CH_NEWLINE;
        if (n < newline_pct + 10) return CH_TAB;
        if (n < newline_pct + 24) return CH_BACKSPACE;
        if (n < newline_pct + 27) return CH_KILL_LINE;
        if (n < newline_pct + 37) return CH_W'($urandom_range(0, 255));
        return CH_W'($urandom_range(8'h20, 8'h7E));
    endfunction

    initial begin
        logic [VAL_W-1:0] color;
        logic [VAL_W-1:0] rows;
        int               newline_pct;
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_COLOR_ATTRIBUTE;
        i_cfg_data    = '0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        stall_req     = 1'b0;
        stall_left    = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening at the reset settings
        foreach (OPENING_CHARS[i]) send_char(OPENING_CHARS[i]);

        // Random phases, each under its own register settings and idling
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin color = 16'h0700; rows = 16'd25; end
                1: begin color = 16'hFF00; rows = 16'd32; end
                2: begin color = VAL_W'($urandom); rows = 16'd3; end
                3: begin color = 16'h0000; rows = 16'd0; end
                4: begin color = 16'hFFFF; rows = 16'd63; end
                5: begin color = VAL_W'($urandom); rows = VAL_W'($urandom_range(1, 32)); end
                6: begin color = 16'h0700; rows = 16'd25; end
                7: begin color = VAL_W'($urandom); rows = 16'd1; end
                default: begin
                    color = VAL_W'($urandom);
                    rows  = {10'($urandom), 6'($urandom_range(0, 63))};
                end
            endcase
            wait_idle();
            configure(color, rows);
            case (p / 3)
                0: begin src_idle_pct = 11; sink_idle_pct = 73; end
                1: begin src_idle_pct = 73; sink_idle_pct = 11; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            // Sparse newlines let lines run past the right edge
            newline_pct = (p % 2 == 1) ? 2 : 14;
            if (p == 6) stall_req = 1'b1;
            for (int k = 0; k < PHASE_REQUESTS; k++) send_char(pick_char(newline_pct));
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[text_console_cursor_engine_top] OK");
        end else begin
            $display("[text_console_cursor_engine_top] ERROR");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #3_000_000;
        $display("[text_console_cursor_engine_top] ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tcce_pkg.sv
rtl/tcce_front.sv
rtl/tcce_queue.sv
rtl/tcce_back.sv
rtl/text_console_cursor_engine_top.sv
rtl/tcce_checker.sv
tb/text_console_cursor_engine_top_tb.sv
